// ===== hw/rtl/admu_pkg.sv =====
// ----------------------------------------------------------------------------
// admu_pkg
// Shared types, codes and helpers for the data-processing / multiply unit.
// ----------------------------------------------------------------------------
package admu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned RIDX_W   = $clog2(NUM_REGS);
  localparam int unsigned FLAGS_W  = 4;

  // flag bit positions in nzcv
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  // register index that multiply encodings may not use
  localparam logic [RIDX_W-1:0] REG_PC = 4'hF;

  // instruction class on in_opcode
  localparam logic CLS_DATA_PROC = 1'b0;
  localparam logic CLS_MULTIPLY  = 1'b1;

  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } alu_op_t;

  // the three register file read ports
  typedef struct packed {
    logic [RIDX_W-1:0] a;
    logic [RIDX_W-1:0] b;
    logic [RIDX_W-1:0] c;
  } rf_addr_t;

  // port a: rn for data processing, rm for multiply
  // port b: rm for data processing, rs for multiply
  // port c: rn (accumulate) for multiply
  function automatic rf_addr_t rf_addr_decode(input logic cls, input logic [XLEN-1:0] ins);
    rf_addr_t addr;
    if (cls == CLS_MULTIPLY) begin
      addr.a = ins[3:0];
      addr.b = ins[11:8];
      addr.c = ins[15:12];
    end else begin
      addr.a = ins[19:16];
      addr.b = ins[3:0];
      addr.c = ins[15:12];
    end
    return addr;
  endfunction

  function automatic logic [XLEN-1:0] rot_imm(input logic [XLEN-1:0] ins);
    logic [2*XLEN-1:0] dbl;
    logic [4:0]        rot;
    rot = {ins[11:8], 1'b0};
    dbl = {{(XLEN-8){1'b0}}, ins[7:0], {(XLEN-8){1'b0}}, ins[7:0]} >> rot;
    return dbl[XLEN-1:0];
  endfunction

endpackage

// ===== hw/rtl/arm_data_processing_multiply_unit_top.sv =====
// ----------------------------------------------------------------------------
// arm_data_processing_multiply_unit_top
// Executes data-processing and MUL/MLA words against a 16 x 32 register file.
//
// Input channel in_*: one instruction word per handshake, in_opcode selects
// data processing or multiply. Output channel out_*: exactly one result word
// per instruction, in order, giving the write, the result and NZCV after it.
// A word passes the execute and finish stages into the output register, which
// drives out_valid. Throughput is one word per cycle while no interlock or
// output stall holds it; the register file is three copies of a 1W1R RAM (one
// per operand port) and results are forwarded from the finish stage. The
// accumulate add of a multiply sits in the finish stage, so a word whose
// register fields name the multiply's destination, or any word that follows
// a flag-setting multiply, waits in the execute stage until the multiply moves
// on. A stalled output holds in the output register; the finish and execute
// stages fill behind it before in_stall rises. Reset (synchronous, rst_n low)
// clears pipeline, flags and register valid bits; unwritten registers read 0.
// ----------------------------------------------------------------------------
module arm_data_processing_multiply_unit_top
  import admu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [XLEN-1:0]       in_instruction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_reg_written,
  output logic [RIDX_W-1:0]     out_dest_reg,
  output logic [XLEN-1:0]       out_result_value,
  output logic [FLAGS_W-1:0]    out_flags,
  output logic                  out_rejected
);

  // pipeline handshake
  logic accept, move1, move2, out_take, hazard;
  logic v1_r, v2_r, vo_r;

  // architectural flags and register valid bits
  logic [FLAGS_W-1:0]  flags_r;
  logic [NUM_REGS-1:0] rvalid_r;

  // execute stage
  logic            s1_cls_r;
  logic [XLEN-1:0] s1_ins_r;
  rf_addr_t        in_addr, s1_addr;
  logic [XLEN-1:0] ram_q_a, ram_q_b, ram_q_c;
  logic [2:0]      rq_valid_r;
  logic [2:0]      sel_hold_r;
  logic [XLEN-1:0] hold_a_r, hold_b_r, hold_c_r;
  logic [XLEN-1:0] base_a, base_b, base_c;
  logic [XLEN-1:0] opa, opb, opc;
  logic [FLAGS_W-1:0] fl_cur;

  // finish stage
  logic               s2_mul_r, s2_wr_r, s2_s_r, s2_rej_r;
  logic [RIDX_W-1:0]  s2_rd_r;
  logic [XLEN-1:0]    s2_val_r, s2_add_r;
  logic [FLAGS_W-1:0] s2_flags_r;
  logic [XLEN-1:0]    res2;
  logic [FLAGS_W-1:0] flags2;
  logic               wr_commit;

  // execute results
  logic               x_wr, x_s, x_rej;
  logic [RIDX_W-1:0]  x_rd;
  logic [XLEN-1:0]    x_val, x_add;
  logic [FLAGS_W-1:0] x_flags;

  // ------------------------------------------------------------ handshake
  assign out_take = vo_r & ~out_stall;
  assign move2    = v2_r & (~vo_r | out_take);
  assign move1    = v1_r & (~v2_r | move2) & ~hazard;
  assign in_stall = v1_r & ~move1;
  assign accept   = in_valid & ~in_stall;

  assign wr_commit = move2 & s2_wr_r;

  // ------------------------------------------------------------ register file
  assign in_addr = rf_addr_decode(in_opcode, in_instruction);
  assign s1_addr = rf_addr_decode(s1_cls_r, s1_ins_r);

  admu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
    .clk     (clk),
    .wr_en   (wr_commit),
    .wr_addr (s2_rd_r),
    .wr_data (res2),
    .rd_en   (accept),
    .rd_addr (in_addr.a),
    .rd_data (ram_q_a)
  );

  admu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
    .clk     (clk),
    .wr_en   (wr_commit),
    .wr_addr (s2_rd_r),
    .wr_data (res2),
    .rd_en   (accept),
    .rd_addr (in_addr.b),
    .rd_data (ram_q_b)
  );

  admu_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_c (
    .clk     (clk),
    .wr_en   (wr_commit),
    .wr_addr (s2_rd_r),
    .wr_data (res2),
    .rd_en   (accept),
    .rd_addr (in_addr.c),
    .rd_data (ram_q_c)
  );

  // never-written registers read as zero
  assign base_a = sel_hold_r[0] ? hold_a_r : (rq_valid_r[0] ? ram_q_a : '0);
  assign base_b = sel_hold_r[1] ? hold_b_r : (rq_valid_r[1] ? ram_q_b : '0);
  assign base_c = sel_hold_r[2] ? hold_c_r : (rq_valid_r[2] ? ram_q_c : '0);

  // forward from the finish stage; a multiply there is covered by the hazard
  always_comb begin
    logic fwd_ok;
    fwd_ok = v2_r & s2_wr_r;
    opa    = (fwd_ok && s2_rd_r == s1_addr.a) ? s2_val_r : base_a;
    opb    = (fwd_ok && s2_rd_r == s1_addr.b) ? s2_val_r : base_b;
    opc    = (fwd_ok && s2_rd_r == s1_addr.c) ? s2_val_r : base_c;
    fl_cur = v2_r ? s2_flags_r : flags_r;
  end

  assign hazard = v1_r & v2_r & s2_mul_r & s2_wr_r &
                  (s2_s_r | s2_rd_r == s1_addr.a | s2_rd_r == s1_addr.b |
                   s2_rd_r == s1_addr.c);

  // ------------------------------------------------------------ execute
  always_comb begin
    alu_op_t          op;
    logic [XLEN-1:0]  op2, imm_r, add_a, add_b, res;
    logic [XLEN:0]    sum;
    logic             add_ci, sh_c, c_out, v_out, arith;
    logic [RIDX_W-1:0] m_rd, m_rn, m_rs, m_rm;
    logic             m_acc, m_bad;

    op     = alu_op_t'(s1_ins_r[24:21]);
    imm_r  = rot_imm(s1_ins_r);
    // only a rotated immediate gives its own carry
    sh_c   = (s1_ins_r[25] && s1_ins_r[11:8] != 4'h0) ? imm_r[XLEN-1] : fl_cur[FLAG_C];
    op2    = s1_ins_r[25] ? imm_r : opb;
    add_a  = opa;
    add_b  = op2;
    add_ci = 1'b0;
    arith  = 1'b1;
    case (op)
      OP_SUB, OP_CMP: begin
        add_b  = ~op2;
        add_ci = 1'b1;
      end
      OP_RSB: begin
        add_a  = op2;
        add_b  = ~opa;
        add_ci = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_ci = 1'b0;
      end
      OP_ADC: begin
        add_ci = fl_cur[FLAG_C];
      end
      OP_SBC: begin
        add_b  = ~op2;
        add_ci = fl_cur[FLAG_C];
      end
      OP_RSC: begin
        add_a  = op2;
        add_b  = ~opa;
        add_ci = fl_cur[FLAG_C];
      end
      default: begin
        arith = 1'b0;
      end
    endcase
    sum   = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, add_ci};
    c_out = arith ? sum[XLEN] : sh_c;
    v_out = arith ? (~(add_a[XLEN-1] ^ add_b[XLEN-1]) & (add_a[XLEN-1] ^ sum[XLEN-1]))
                  : fl_cur[FLAG_V];
    case (op)
      OP_AND, OP_TST: res = opa & op2;
      OP_EOR, OP_TEQ: res = opa ^ op2;
      OP_ORR:         res = opa | op2;
      OP_MOV:         res = op2;
      OP_BIC:         res = opa & ~op2;
      OP_MVN:         res = ~op2;
      default:        res = sum[XLEN-1:0];
    endcase

    m_rd  = s1_ins_r[19:16];
    m_rn  = s1_ins_r[15:12];
    m_rs  = s1_ins_r[11:8];
    m_rm  = s1_ins_r[3:0];
    m_acc = s1_ins_r[21];
    m_bad = (m_rd == REG_PC) || (m_rs == REG_PC) || (m_rm == REG_PC) || (m_rd == m_rm) ||
            (m_acc ? (m_rn == REG_PC) : (m_rn != '0));

    if (s1_cls_r == CLS_MULTIPLY) begin
      x_rd    = m_rd;
      x_rej   = m_bad;
      x_wr    = ~m_bad;
      x_s     = s1_ins_r[20] & ~m_bad;
      x_flags = fl_cur;
      x_val   = m_bad ? '0 : opa * opb;
      x_add   = (m_bad || !m_acc) ? '0 : opc;
    end else begin
      x_rd    = s1_ins_r[15:12];
      x_rej   = 1'b0;
      x_wr    = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      x_s     = s1_ins_r[20];
      x_flags = s1_ins_r[20] ? {res[XLEN-1], res == '0, c_out, v_out} : fl_cur;
      x_val   = res;
      x_add   = '0;
    end
  end

  // ------------------------------------------------------------ finish
  assign res2   = s2_val_r + s2_add_r;
  assign flags2 = (s2_mul_r && s2_s_r) ? {res2[XLEN-1], res2 == '0, s2_flags_r[1:0]}
                                       : s2_flags_r;

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vo_r     <= 1'b0;
      flags_r  <= '0;
      rvalid_r <= '0;
    end else begin
      if (accept) begin
        v1_r <= 1'b1;
      end else if (move1) begin
        v1_r <= 1'b0;
      end
      if (move1) begin
        v2_r <= 1'b1;
      end else if (move2) begin
        v2_r <= 1'b0;
      end
      if (move2) begin
        vo_r <= 1'b1;
      end else if (out_take) begin
        vo_r <= 1'b0;
      end
      if (move2) begin
        flags_r <= flags2;
      end
      if (wr_commit) begin
        rvalid_r[s2_rd_r] <= 1'b1;
      end
    end
  end

  // operand capture: a write committing in the same cycle as the ram read,
  // or while the word waits here, replaces the stale ram data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls_r      <= in_opcode;
      s1_ins_r      <= in_instruction;
      rq_valid_r[0] <= rvalid_r[in_addr.a];
      rq_valid_r[1] <= rvalid_r[in_addr.b];
      rq_valid_r[2] <= rvalid_r[in_addr.c];
      sel_hold_r[0] <= wr_commit && s2_rd_r == in_addr.a;
      sel_hold_r[1] <= wr_commit && s2_rd_r == in_addr.b;
      sel_hold_r[2] <= wr_commit && s2_rd_r == in_addr.c;
      hold_a_r      <= res2;
      hold_b_r      <= res2;
      hold_c_r      <= res2;
    end else if (v1_r && !move1) begin
      sel_hold_r <= 3'b111;
      hold_a_r   <= (wr_commit && s2_rd_r == s1_addr.a) ? res2 : base_a;
      hold_b_r   <= (wr_commit && s2_rd_r == s1_addr.b) ? res2 : base_b;
      hold_c_r   <= (wr_commit && s2_rd_r == s1_addr.c) ? res2 : base_c;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      s2_mul_r   <= s1_cls_r;
      s2_wr_r    <= x_wr;
      s2_s_r     <= x_s;
      s2_rej_r   <= x_rej;
      s2_rd_r    <= x_rd;
      s2_val_r   <= x_val;
      s2_add_r   <= x_add;
      s2_flags_r <= x_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      out_reg_written  <= s2_wr_r;
      out_dest_reg     <= s2_rd_r;
      out_result_value <= res2;
      out_flags        <= flags2;
      out_rejected     <= s2_rej_r;
    end
  end

  assign out_valid = vo_r;

  // ------------------------------------------------------------ checks
  a_rej_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    move2 && s2_rej_r |-> !s2_wr_r && res2 == '0)
    else $error("rejected multiply would write the register file");

  a_hazard_mul: assert property (@(posedge clk) disable iff (!rst_n)
    hazard |-> v2_r && s2_mul_r)
    else $error("interlock raised without a multiply in the finish stage");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !move2 |=> $stable(flags_r))
    else $error("flags changed without a retiring word");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted word lost from the execute stage");

endmodule

// ===== hw/rtl/admu_ram.sv =====
// ----------------------------------------------------------------------------
// admu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module admu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== test/tb_arm_data_processing_multiply_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_data_processing_multiply_unit_top
// Runs a table of hand-picked ALU and MUL/MLA words, then about 1200 random
// words, under random sender gaps and receiver stalls. Every result word is
// checked field by field against an in-order model of the register file and
// the NZCV flags.
// ----------------------------------------------------------------------------
module tb_arm_data_processing_multiply_unit_top;
  import admu_pkg::*;

  typedef struct packed {
    logic              reg_written;
    logic [RIDX_W-1:0] dest_reg;
    logic [XLEN-1:0]   result_value;
    logic [FLAGS_W-1:0] flags;
    logic              rejected;
  } retire_t;

  typedef struct packed {
    logic            cls;
    logic [XLEN-1:0] ins;
    logic            known;
    retire_t         want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_opcode = 1'b0;
  logic [XLEN-1:0]     in_instruction = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_reg_written;
  logic [RIDX_W-1:0]   out_dest_reg;
  logic [XLEN-1:0]     out_result_value;
  logic [FLAGS_W-1:0]  out_flags;
  logic                out_rejected;

  // model state
  logic [XLEN-1:0]     gpr [NUM_REGS];
  logic [FLAGS_W-1:0]  nzcv;

  retire_t   retire_q [$];
  stim_row_t stim_rows [$];

  int send_idle_pct  = 35;
  int recv_stall_pct = 87;
  int mismatch_cnt   = 0;
  int checked_cnt    = 0;
  int sent_cnt       = 0;
  int mul_cnt        = 0;
  int reject_cnt     = 0;

  arm_data_processing_multiply_unit_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_instruction   (in_instruction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reg_written  (out_reg_written),
    .out_dest_reg     (out_dest_reg),
    .out_result_value (out_result_value),
    .out_flags        (out_flags),
    .out_rejected     (out_rejected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still outstanding", retire_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [XLEN-1:0] dp_word(input logic imm_op, input alu_op_t op,
                                               input logic s, input logic [3:0] rn,
                                               input logic [3:0] rd, input logic [11:0] op2);
    return {4'hE, 2'b00, imm_op, op, s, rn, rd, op2};
  endfunction

  function automatic logic [XLEN-1:0] mul_word(input logic acc, input logic s,
                                               input logic [3:0] rd, input logic [3:0] rn,
                                               input logic [3:0] rs, input logic [3:0] rm);
    return {4'hE, 6'b000000, acc, s, rd, rn, rs, 4'b1001, rm};
  endfunction

  function automatic stim_row_t stim_row(input logic cls, input logic [XLEN-1:0] ins,
                                         input logic known, input logic wr,
                                         input logic [3:0] rd, input logic [XLEN-1:0] val,
                                         input logic [3:0] f, input logic rej);
    stim_row_t row;
    row.cls               = cls;
    row.ins               = ins;
    row.known             = known;
    row.want.reg_written  = wr;
    row.want.dest_reg     = rd;
    row.want.result_value = val;
    row.want.flags        = f;
    row.want.rejected     = rej;
    return row;
  endfunction

  function automatic logic [XLEN-1:0] add_with_carry(input logic [XLEN-1:0] x,
                                                     input logic [XLEN-1:0] y,
                                                     input logic ci, output logic co,
                                                     output logic ov);
    logic [XLEN:0] sum;
    sum = {1'b0, x} + {1'b0, y} + {{XLEN{1'b0}}, ci};
    co  = sum[XLEN];
    ov  = ~(x[XLEN-1] ^ y[XLEN-1]) & (x[XLEN-1] ^ sum[XLEN-1]);
    return sum[XLEN-1:0];
  endfunction

  // executes one word on the model state and returns its result word
  task automatic execute_word(input logic cls, input logic [XLEN-1:0] ins,
                              output retire_t r);
    alu_op_t         op;
    logic [XLEN-1:0] a, b, res, imm;
    logic            c, v, cin, write, bad;
    int unsigned     rot;
    r = '0;
    if (cls == CLS_MULTIPLY) begin
      bad = ins[19:16] == REG_PC || ins[11:8] == REG_PC || ins[3:0] == REG_PC ||
            ins[19:16] == ins[3:0] ||
            (ins[21] ? ins[15:12] == REG_PC : ins[15:12] != 4'd0);
      r.dest_reg = ins[19:16];
      if (bad) begin
        r.rejected = 1'b1;
      end else begin
        res = gpr[ins[3:0]] * gpr[ins[11:8]];
        if (ins[21]) res = res + gpr[ins[15:12]];
        gpr[ins[19:16]] = res;
        // multiply keeps c and v
        if (ins[20]) begin
          nzcv[FLAG_N] = res[XLEN-1];
          nzcv[FLAG_Z] = (res == '0);
        end
        r.reg_written  = 1'b1;
        r.result_value = res;
      end
      r.flags = nzcv;
    end else begin
      op  = alu_op_t'(ins[24:21]);
      a   = gpr[ins[19:16]];
      cin = nzcv[FLAG_C];
      c   = cin;
      v   = nzcv[FLAG_V];
      if (ins[25]) begin
        imm = {24'd0, ins[7:0]};
        rot = ins[11:8] * 2;
        if (rot != 0) begin
          b = (imm >> rot) | (imm << (32 - rot));
          c = b[XLEN-1];
        end else begin
          b = imm;
        end
      end else begin
        b = gpr[ins[3:0]];
      end
      case (op)
        OP_AND, OP_TST: res = a & b;
        OP_EOR, OP_TEQ: res = a ^ b;
        OP_SUB, OP_CMP: res = add_with_carry(a, ~b, 1'b1, c, v);
        OP_RSB:         res = add_with_carry(b, ~a, 1'b1, c, v);
        OP_ADD, OP_CMN: res = add_with_carry(a, b, 1'b0, c, v);
        OP_ADC:         res = add_with_carry(a, b, cin, c, v);
        OP_SBC:         res = add_with_carry(a, ~b, cin, c, v);
        OP_RSC:         res = add_with_carry(b, ~a, cin, c, v);
        OP_ORR:         res = a | b;
        OP_MOV:         res = b;
        OP_BIC:         res = a & ~b;
        default:        res = ~b;
      endcase
      write = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
      if (write) gpr[ins[15:12]] = res;
      if (ins[20]) nzcv = {res[XLEN-1], res == '0, c, v};
      r.reg_written  = write;
      r.dest_reg     = ins[15:12];
      r.result_value = res;
      r.flags        = nzcv;
    end
  endtask

  // drives one word, waits for it to be taken, then records what it should retire
  task automatic send_word(input logic cls, input logic [XLEN-1:0] ins,
                           input logic known, input retire_t want);
    retire_t got;
    // idle decision is made per cycle
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= cls;
    in_instruction <= ins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    execute_word(cls, ins, got);
    retire_q.push_back(known ? want : got);
    sent_cnt++;
    if (cls == CLS_MULTIPLY) mul_cnt++;
    if (got.rejected) reject_cnt++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    retire_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.reg_written  = out_reg_written;
      got.dest_reg     = out_dest_reg;
      got.result_value = out_result_value;
      got.flags        = out_flags;
      got.rejected     = out_rejected;
      if (retire_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result word with nothing outstanding: wr=%0b rd=%0d val=%h f=%b rej=%0b",
                   $realtime, got.reg_written, got.dest_reg, got.result_value, got.flags,
                   got.rejected);
      end else begin
        want = retire_q.pop_front();
        checked_cnt++;
        if (got.reg_written !== want.reg_written || got.dest_reg !== want.dest_reg ||
            got.result_value !== want.result_value || got.flags !== want.flags ||
            got.rejected !== want.rejected) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result %0d mismatch", $realtime, checked_cnt);
            $display("  expected wr=%0b rd=%0d val=%h f=%b rej=%0b", want.reg_written,
                     want.dest_reg, want.result_value, want.flags, want.rejected);
            $display("  actual   wr=%0b rd=%0d val=%h f=%b rej=%0b", got.reg_written,
                     got.dest_reg, got.result_value, got.flags, got.rejected);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic            cls;
    logic [XLEN-1:0] ins;
    logic [3:0]      rd, rm;
    int              pick;

    foreach (gpr[i]) gpr[i] = '0;
    nzcv = '0;

    // flags in the comments are nzcv after the word
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_MOV, 1, 0, 1, 12'h000),
                                 1, 1, 1, 32'h0000_0000, 4'b0100, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_MVN, 1, 0, 2, 12'h000),
                                 1, 1, 2, 32'hFFFF_FFFF, 4'b1000, 0));
    // rotated immediate, carry from bit 31
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_MOV, 1, 0, 3, 12'h4FF),
                                 1, 1, 3, 32'hFF00_0000, 4'b1010, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_SUB, 1, 1, 5, 12'h001),
                                 1, 1, 5, 32'hFFFF_FFFF, 4'b1000, 0));
    // s clear keeps flags
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_MVN, 0, 0, 6, 12'h102),
                                 1, 1, 6, 32'h7FFF_FFFF, 4'b1000, 0));
    // signed overflow
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_ADD, 1, 6, 7, 12'h001),
                                 1, 1, 7, 32'h8000_0000, 4'b1001, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_ADC, 1, 6, 8, 12'h002),
                                 1, 1, 8, 32'h7FFF_FFFE, 4'b0010, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_SBC, 1, 1, 9, 12'h001),
                                 1, 1, 9, 32'h0000_0000, 4'b0110, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_RSB, 1, 2, 10, 12'h000),
                                 1, 1, 10, 32'h0000_0001, 4'b0000, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_RSC, 1, 10, 11, 12'h007),
                                 1, 1, 11, 32'h7FFF_FFFE, 4'b0011, 0));
    // compares: no write, result still shown
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_TST, 1, 2, 12, 12'h000),
                                 1, 0, 12, 32'h0000_0000, 4'b0111, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_TEQ, 1, 2, 0, 12'h001),
                                 1, 0, 0, 32'hFFFF_FFFF, 4'b1011, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_CMP, 1, 1, 0, 12'h001),
                                 1, 0, 0, 32'h0000_0000, 4'b0110, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_CMN, 1, 7, 0, 12'h007),
                                 1, 0, 0, 32'h0000_0000, 4'b0111, 0));
    // logical with register operand keeps old carry and v
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_ORR, 1, 1, 12, 12'h003),
                                 1, 1, 12, 32'hFF00_0000, 4'b1011, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_BIC, 1, 2, 13, 12'h101),
                                 1, 1, 13, 32'hBFFF_FFFF, 4'b1001, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_EOR, 0, 2, 14, 12'h0FF),
                                 1, 1, 14, 32'hFFFF_FF00, 4'b1001, 0));
    // r15 is a plain register
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(0, OP_AND, 0, 2, 15, 12'h003),
                                 1, 1, 15, 32'hFF00_0000, 4'b1001, 0));
    // bad multiply encodings
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(0, 1, 15, 0, 1, 2),
                                 1, 0, 15, 32'h0, 4'b1001, 1));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(0, 0, 4, 0, 1, 4),
                                 1, 0, 4, 32'h0, 4'b1001, 1));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(1, 0, 3, 15, 1, 2),
                                 1, 0, 3, 32'h0, 4'b1001, 1));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(0, 0, 3, 5, 1, 2),
                                 1, 0, 3, 32'h0, 4'b1001, 1));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(1, 1, 3, 0, 15, 2),
                                 1, 0, 3, 32'h0, 4'b1001, 1));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(0, 0, 3, 0, 1, 15),
                                 1, 0, 3, 32'h0, 4'b1001, 1));
    // the rest go through the model
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(0, 1, 0, 0, 6, 6), 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CLS_MULTIPLY, mul_word(1, 1, 1, 7, 2, 2), 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(stim_row(CLS_DATA_PROC, dp_word(1, OP_ORR, 1, 15, 14, 12'hFFF),
                                 0, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send_word(stim_rows[i].cls, stim_rows[i].ins, stim_rows[i].known, stim_rows[i].want);

    for (int n = 0; n < 1200; n++) begin
      if (n == 400) begin
        send_idle_pct  = 87;
        recv_stall_pct = 35;
      end else if (n == 800) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      pick = $urandom_range(0, 99);
      ins  = $urandom;
      if (pick < 15) begin
        // load a register with a rotated immediate
        cls         = CLS_DATA_PROC;
        ins[25]     = 1'b1;
        ins[24:21]  = $urandom_range(0, 1) ? OP_MOV : OP_MVN;
      end else if (pick < 55) begin
        cls = CLS_DATA_PROC;
      end else if (pick < 85) begin
        // well-formed mul / mla, other bits random
        cls = CLS_MULTIPLY;
        rd  = 4'($urandom_range(0, 14));
        do rm = 4'($urandom_range(0, 14)); while (rm == rd);
        ins[19:16] = rd;
        ins[11:8]  = 4'($urandom_range(0, 14));
        ins[3:0]   = rm;
        ins[15:12] = ins[21] ? 4'($urandom_range(0, 14)) : 4'd0;
      end else begin
        cls = CLS_MULTIPLY;
      end
      send_word(cls, ins, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d words sent, %0d of them multiplies (%0d bad encodings)",
             sent_cnt, mul_cnt, reject_cnt);
    $display("%0d result words checked, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
